// File: hw/rtl/tmcg_pkg.sv
`default_nettype none

package tmcg_pkg;

  // Font store geometry.
  localparam int unsigned GLYPH_STORE_DEPTH = 2048;
  localparam int unsigned GLYPH_ADDR_W      = $clog2(GLYPH_STORE_DEPTH);

  // Opcodes of an input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_TEXT         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_START     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_POSITION   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_FIRST_LINE = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CURSOR_STOP_LINE  = 3'd5;

  // Screen geometry.
  localparam logic [4:0] TEXT_ROWS     = 5'd25;
  localparam logic [6:0] COLS_WIDE     = 7'd80;
  localparam logic [6:0] COLS_NARROW   = 7'd40;
  localparam logic [8:0] STRIDE_WIDE   = 9'd320;
  localparam logic [8:0] STRIDE_NARROW = 9'd160;
  localparam logic [2:0] LAST_SCAN     = 3'd7;

  localparam logic [31:0] CURSOR_WORD = 32'hFFFF_FFFF;

  // Configuration register file contents.
  typedef struct packed {
    logic        video_enable;
    logic        wide_text;
    logic [13:0] display_start;
    logic [13:0] cursor_position;
    logic [4:0]  cursor_first_line;
    logic [4:0]  cursor_stop_line;
  } tmcg_cfg_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic                    is_load;
    logic [GLYPH_ADDR_W-1:0] glyph_addr;
    logic [7:0]              glyph_value;
    logic [7:0]              char_code;
    logic [3:0]              fg;
    logic [3:0]              bg;
    logic                    on_cursor;
    logic [15:0]             base_offset;
  } tmcg_entry_t;

  // Expand one font row into eight 4-bit pixels, leftmost pixel on top.
  function automatic logic [31:0] expand_line(logic [7:0] bits, logic [3:0] fg,
                                              logic [3:0] bg);
    logic [31:0] word;
    word = '0;
    for (int i = 0; i < 8; i++) begin
      word[4*i +: 4] = bits[i] ? fg : bg;
    end
    return word;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tmcg_front.sv
`default_nettype none

module tmcg_front
  import tmcg_pkg::*;
(
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [10:0] glyph_byte_index_i,
  input  wire logic [7:0]  glyph_byte_value_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  attribute_i,
  input  wire logic [4:0]  cell_row_i,
  input  wire logic [6:0]  cell_col_i,
  input  wire tmcg_cfg_t   cfg_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output tmcg_entry_t      q_entry_o
);

  logic        in_range;
  logic [11:0] row_base;
  logic [13:0] cell_addr;
  logic [15:0] row_ext;
  logic [15:0] line_base;
  logic [15:0] col_bytes;

  // The queue's fill level alone holds off the upstream side.
  assign in_stall_o = q_full_i;

  // Cells outside the active text area are dropped here.
  assign in_range = (cell_row_i < TEXT_ROWS) &&
                    (cell_col_i < (cfg_i.wide_text ? COLS_WIDE : COLS_NARROW));

  // Character index of the cell: row times 80 or 40 by shifts and adds.
  assign row_base = cfg_i.wide_text ?
                    (({7'b0, cell_row_i} << 6) + ({7'b0, cell_row_i} << 4)) :
                    (({7'b0, cell_row_i} << 5) + ({7'b0, cell_row_i} << 3));
  assign cell_addr = cfg_i.display_start + {2'b0, row_base} + {7'b0, cell_col_i};

  // Byte offset of the cell's top line: row * 8 * stride + col * 4.
  assign row_ext   = {11'b0, cell_row_i};
  assign line_base = cfg_i.wide_text ? ((row_ext << 11) + (row_ext << 9)) :
                                       ((row_ext << 10) + (row_ext << 8));
  assign col_bytes = {7'b0, cell_col_i, 2'b0};

  // Classify the item and build its queue entry.
  always_comb begin
    q_entry_o.is_load     = (opcode_i == OP_LOAD);
    q_entry_o.glyph_addr  = glyph_byte_index_i;
    q_entry_o.glyph_value = glyph_byte_value_i;
    q_entry_o.char_code   = char_code_i;
    q_entry_o.fg          = attribute_i[3:0];
    q_entry_o.bg          = attribute_i[7:4];
    q_entry_o.on_cursor   = (cell_addr == cfg_i.cursor_position);
    q_entry_o.base_offset = line_base + col_bytes;
  end

  assign q_push_o = in_valid_i && !q_full_i && ((opcode_i == OP_LOAD) || in_range);

endmodule

`default_nettype wire

// File: hw/rtl/tmcg_fifo.sv
`default_nettype none

module tmcg_fifo
  import tmcg_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire tmcg_entry_t entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output tmcg_entry_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tmcg_entry_t      slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("queue fill level out of range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/tmcg_back.sv
`default_nettype none

module tmcg_back
  import tmcg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tmcg_cfg_t   cfg_i,
  input  wire logic        q_empty_i,
  input  wire tmcg_entry_t q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       scan_index_o,
  output logic [31:0]      pixel_word_o,
  output logic [15:0]      frame_offset_o,
  output logic             last_line_o
);

  // Font store.
  logic [7:0] glyph_mem [GLYPH_STORE_DEPTH];
  logic [7:0] rdata_q;

  // Issue stage: the cell being walked line by line.
  logic        active_q, active_d;
  logic [2:0]  line_q, line_d;
  logic [7:0]  cur_char_q;
  logic [3:0]  cur_fg_q, cur_bg_q;
  logic        cur_cursor_q;
  logic [15:0] cur_off_q, cur_off_d;

  // Read stage: metadata that waits beside the font read.
  logic        b_valid_q;
  logic [2:0]  b_line_q;
  logic [3:0]  b_fg_q, b_bg_q;
  logic        b_force_q;
  logic        b_blank_q;
  logic [15:0] b_off_q;

  // Output register.
  logic        c_valid_q;
  logic [2:0]  c_line_q;
  logic [31:0] c_pixel_q;
  logic [15:0] c_off_q;
  logic        c_last_q;

  logic        en;
  logic        issue;
  logic        last_issue;
  logic        pop;
  logic        load_pop;
  logic [4:0]  line_ext;
  logic        cursor_line;
  logic [8:0]  stride;

  // The whole line pipeline moves when the output register is free.
  assign en         = !c_valid_q || !out_stall_i;
  assign issue      = active_q && en;
  assign last_issue = issue && (line_q == LAST_SCAN);
  assign pop        = !q_empty_i && (!active_q || last_issue);
  assign load_pop   = pop && q_head_i.is_load;
  assign q_pop_o    = pop;

  assign stride      = cfg_i.wide_text ? STRIDE_WIDE : STRIDE_NARROW;
  assign line_ext    = {2'b0, line_q};
  assign cursor_line = cur_cursor_q && (line_ext >= cfg_i.cursor_first_line) &&
                       (line_ext < cfg_i.cursor_stop_line);

  // Cell sequencer next state.
  always_comb begin
    active_d  = active_q;
    line_d    = line_q;
    cur_off_d = cur_off_q;
    if (issue) begin
      line_d    = line_q + 1'b1;
      cur_off_d = cur_off_q + {7'b0, stride};
    end
    if (last_issue) begin
      active_d = 1'b0;
    end
    if (pop) begin
      active_d  = !q_head_i.is_load;
      line_d    = '0;
      cur_off_d = q_head_i.base_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      line_q    <= '0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      line_q   <= line_d;
      if (en) begin
        b_valid_q <= issue;
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Cell payload registers.
  always_ff @(posedge clk_i) begin
    cur_off_q <= cur_off_d;
    if (pop) begin
      cur_char_q   <= q_head_i.char_code;
      cur_fg_q     <= q_head_i.fg;
      cur_bg_q     <= q_head_i.bg;
      cur_cursor_q <= q_head_i.on_cursor;
    end
  end

  // Font store: one write port for loads, one registered read for lines.
  always_ff @(posedge clk_i) begin
    if (load_pop) begin
      glyph_mem[q_head_i.glyph_addr] <= q_head_i.glyph_value;
    end
    if (issue) begin
      rdata_q <= glyph_mem[{cur_char_q, line_q}];
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_line_q  <= line_q;
      b_fg_q    <= cur_fg_q;
      b_bg_q    <= cur_bg_q;
      b_force_q <= cursor_line;
      b_blank_q <= !cfg_i.video_enable;
      b_off_q   <= cur_off_q;
    end
  end

  // Pixel expansion into the output register.
  always_ff @(posedge clk_i) begin
    if (en && b_valid_q) begin
      c_line_q <= b_line_q;
      c_off_q  <= b_off_q;
      c_last_q <= (b_line_q == LAST_SCAN);
      if (b_blank_q) begin
        c_pixel_q <= '0;
      end else if (b_force_q) begin
        c_pixel_q <= CURSOR_WORD;
      end else begin
        c_pixel_q <= expand_line(rdata_q, b_fg_q, b_bg_q);
      end
    end
  end

  assign out_valid_o    = c_valid_q;
  assign scan_index_o   = c_line_q;
  assign pixel_word_o   = c_pixel_q;
  assign frame_offset_o = c_off_q;
  assign last_line_o    = c_last_q;

`ifndef NO_ASSERTIONS
  a_pop_at_cell_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && active_q) |-> last_issue) else $error("next item taken mid cell");
  a_read_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && out_stall_i && b_valid_q) |=> (b_valid_q && $stable(b_off_q)))
    else $error("read stage moved under a stall");
  a_line_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && line_q != LAST_SCAN) |=> (active_q && line_q == $past(line_q) + 3'd1))
    else $error("scan lines issued out of order");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/text_mode_character_generator.sv
// The first scan line of a cell taken from the queue passes the issue stage, the read
// stage and the output register; the rest follow one per cycle while not stalled.
// A rendered cell needs one font store read per scan line; a queued item is taken as
// its last line issues. Dropped cells cost only their input transfer.
// Reset clears the queue, the line pipeline and all configuration registers;
// the font store holds unknown data until loaded and needs no clearing pass.
`default_nettype none

module text_mode_character_generator
  import tmcg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   opcode_i,
  input  wire logic [10:0]            glyph_byte_index_i,
  input  wire logic [7:0]             glyph_byte_value_i,
  input  wire logic [7:0]             char_code_i,
  input  wire logic [7:0]             attribute_i,
  input  wire logic [4:0]             cell_row_i,
  input  wire logic [6:0]             cell_col_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0]                  scan_index_o,
  output logic [31:0]                 pixel_word_o,
  output logic [15:0]                 frame_offset_o,
  output logic                        last_line_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  tmcg_cfg_t   cfg_q;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  tmcg_entry_t q_entry;
  tmcg_entry_t q_head;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_VIDEO_ENABLE:      cfg_q.video_enable      <= cfg_data_i[0];
        REG_WIDE_TEXT:         cfg_q.wide_text         <= cfg_data_i[0];
        REG_DISPLAY_START:     cfg_q.display_start     <= cfg_data_i;
        REG_CURSOR_POSITION:   cfg_q.cursor_position   <= cfg_data_i;
        REG_CURSOR_FIRST_LINE: cfg_q.cursor_first_line <= cfg_data_i[4:0];
        REG_CURSOR_STOP_LINE:  cfg_q.cursor_stop_line  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Front end: classify items and precompute per-cell values.
  tmcg_front u_front (
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .glyph_byte_index_i (glyph_byte_index_i),
    .glyph_byte_value_i (glyph_byte_value_i),
    .char_code_i        (char_code_i),
    .attribute_i        (attribute_i),
    .cell_row_i         (cell_row_i),
    .cell_col_i         (cell_col_i),
    .cfg_i              (cfg_q),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_entry_o          (q_entry)
  );

  // Queue between front and back end.
  tmcg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Back end: font store and scan line pipeline.
  tmcg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scan_index_o   (scan_index_o),
    .pixel_word_o   (pixel_word_o),
    .frame_offset_o (frame_offset_o),
    .last_line_o    (last_line_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import tmcg_pkg::*;

  // One input transfer as the sender offers it.
  typedef struct packed {
    logic        opcode;
    logic [10:0] glyph_index;
    logic [7:0]  glyph_value;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [4:0]  cell_row;
    logic [6:0]  cell_col;
  } cell_item_t;

  // One scan line result.
  typedef struct packed {
    logic [2:0]  scan_index;
    logic [31:0] pixel_word;
    logic [15:0] frame_offset;
    logic        last_line;
  } scan_line_t;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_GAP       = 12;
  localparam int unsigned ITEM_TARGET   = 410;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  cell_item_t             in_item = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             scan_index;
  logic [31:0]            pixel_word;
  logic [15:0]            frame_offset;
  logic                   last_line;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow of the register file and the font store.
  logic        cfg_video_on = 1'b0;
  logic        cfg_wide_on = 1'b0;
  logic [13:0] cfg_start = '0;
  logic [13:0] cfg_cursor = '0;
  logic [4:0]  cfg_first = '0;
  logic [4:0]  cfg_stop = '0;
  logic [7:0]  font_image [GLYPH_STORE_DEPTH];

  cell_item_t  pending_items [$];
  scan_line_t  expected_lines [$];

  // Glyphs whose eight rows have all been queued for loading.
  bit          glyph_ready [256];
  int unsigned ready_codes [$];

  int unsigned sender_max_gap = MAX_GAP;
  int unsigned receiver_max_stall = MAX_GAP;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned hold_cycles = 0;

  int unsigned items_queued = 0;
  int unsigned loads_done = 0;
  int unsigned cells_rendered = 0;
  int unsigned cells_dropped = 0;
  int unsigned cursor_cells = 0;
  int unsigned lines_checked = 0;
  int unsigned fault_count = 0;
  int unsigned settings_written = 0;

  text_mode_character_generator u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (in_item.opcode),
    .glyph_byte_index_i(in_item.glyph_index),
    .glyph_byte_value_i(in_item.glyph_value),
    .char_code_i       (in_item.char_code),
    .attribute_i       (in_item.attribute),
    .cell_row_i        (in_item.cell_row),
    .cell_col_i        (in_item.cell_col),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .scan_index_o      (scan_index),
    .pixel_word_o      (pixel_word),
    .frame_offset_o    (frame_offset),
    .last_line_o       (last_line),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one accepted transfer to the shadow state and queue the scan lines it yields.
  function automatic void predict_transfer(cell_item_t item);
    int unsigned columns;
    int unsigned stride;
    int unsigned cell_pos;
    logic [7:0]  bits;
    logic [31:0] word;
    logic        at_cursor;
    scan_line_t  line;
    if (item.opcode == OP_LOAD) begin
      font_image[item.glyph_index] = item.glyph_value;
      loads_done++;
      return;
    end
    columns = cfg_wide_on ? COLS_WIDE : COLS_NARROW;
    stride  = cfg_wide_on ? STRIDE_WIDE : STRIDE_NARROW;
    if (item.cell_col >= columns || item.cell_row >= TEXT_ROWS) begin
      cells_dropped++;
      return;
    end
    cell_pos  = cfg_start + item.cell_row * columns + item.cell_col;
    at_cursor = (cell_pos % 16384) == cfg_cursor;
    if (at_cursor && cfg_video_on) begin
      cursor_cells++;
    end
    for (int s = 0; s < 8; s++) begin
      word = '0;
      if (cfg_video_on) begin
        bits = font_image[item.char_code * 8 + s];
        for (int p = 0; p < 8; p++) begin
          word[31 - 4*p -: 4] = bits[7 - p] ? item.attribute[3:0] : item.attribute[7:4];
        end
        if (at_cursor && s >= cfg_first && s < cfg_stop) begin
          word = CURSOR_WORD;
        end
      end
      line.scan_index   = 3'(s);
      line.pixel_word   = word;
      line.frame_offset = 16'((item.cell_row * 8 + s) * stride + item.cell_col * 4);
      line.last_line    = (3'(s) == LAST_SCAN);
      expected_lines.push_back(line);
    end
    cells_rendered++;
  endfunction

  // Sender: offers queued items, holds them while stalled, idles a drawn number of cycles.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_transfer(in_item);
      end
      if (in_valid && in_stall) begin
        // The payload stays put until the transfer happens.
      end else if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_valid  <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item   <= pending_items.pop_front();
        in_valid  <= 1'b1;
        send_wait <= $urandom_range(0, sender_max_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down on its own.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Receiver: checks every transfer against the oldest expected scan line.
  always @(posedge clk or negedge rst_n) begin : result_monitor
    scan_line_t  seen;
    scan_line_t  want;
    int unsigned wait_n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      wait_n = (stall_left != 0) ? stall_left - 1 : 0;
      if (out_valid && !out_stall) begin
        seen   = {scan_index, pixel_word, frame_offset, last_line};
        wait_n = $urandom_range(0, receiver_max_stall);
        if (expected_lines.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected scan line: scan %0d pixels %h offset %0d last %0d",
                     $realtime, seen.scan_index, seen.pixel_word, seen.frame_offset,
                     seen.last_line);
          end
        end else begin
          want = expected_lines.pop_front();
          lines_checked++;
          if (seen.scan_index !== want.scan_index || seen.pixel_word !== want.pixel_word ||
              seen.frame_offset !== want.frame_offset || seen.last_line !== want.last_line) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected scan %0d pixels %h offset %0d last %0d",
                       $realtime, want.scan_index, want.pixel_word, want.frame_offset,
                       want.last_line);
              $display("%0t:           actual scan %0d pixels %h offset %0d last %0d",
                       $realtime, seen.scan_index, seen.pixel_word, seen.frame_offset,
                       seen.last_line);
            end
          end
        end
      end
      stall_left <= wait_n;
      out_stall  <= (wait_n != 0) || (hold_cycles != 0);
    end
  end

  // One register write; the valid stays high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register; called at a rising edge while the block is idle.
  task automatic apply_settings(input logic video, input logic wide, input logic [13:0] start,
                                input logic [13:0] cursor, input logic [4:0] first,
                                input logic [4:0] stop);
    write_reg(REG_VIDEO_ENABLE, video);
    write_reg(REG_WIDE_TEXT, wide);
    write_reg(REG_DISPLAY_START, start);
    write_reg(REG_CURSOR_POSITION, cursor);
    write_reg(REG_CURSOR_FIRST_LINE, first);
    write_reg(REG_CURSOR_STOP_LINE, stop);
    cfg_valid    <= 1'b0;
    cfg_video_on = video;
    cfg_wide_on  = wide;
    cfg_start    = start;
    cfg_cursor   = cursor;
    cfg_first    = first;
    cfg_stop     = stop;
    settings_written++;
  endtask

  // Font byte load; the render fields carry random noise.
  task automatic push_load(input int unsigned index, input int unsigned value);
    cell_item_t item;
    item             = 48'({$urandom, $urandom});
    item.opcode      = OP_LOAD;
    item.glyph_index = 11'(index);
    item.glyph_value = 8'(value);
    pending_items.push_back(item);
    items_queued++;
  endtask

  // Cell render; the load fields carry random noise.
  task automatic push_cell(input int unsigned code, input int unsigned attr,
                           input int unsigned row, input int unsigned col);
    cell_item_t item;
    item           = 48'({$urandom, $urandom});
    item.opcode    = OP_RENDER;
    item.char_code = 8'(code);
    item.attribute = 8'(attr);
    item.cell_row  = 5'(row);
    item.cell_col  = 7'(col);
    pending_items.push_back(item);
    items_queued++;
  endtask

  // All eight rows of one glyph, top row in the highest byte.
  task automatic push_glyph(input int unsigned code, input logic [63:0] rows);
    for (int r = 0; r < 8; r++) begin
      push_load(code * 8 + r, rows[63 - 8*r -: 8]);
    end
    if (!glyph_ready[code]) begin
      glyph_ready[code] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  // Mostly on-screen cells, a share on the cursor cell and some anywhere in the field range.
  task automatic push_random_cell();
    int unsigned columns;
    int unsigned row;
    int unsigned col;
    int unsigned code;
    int unsigned pick;
    logic [13:0] cursor_gap;
    columns    = cfg_wide_on ? COLS_WIDE : COLS_NARROW;
    cursor_gap = cfg_cursor - cfg_start;
    pick       = $urandom_range(0, 19);
    if (pick == 0) begin
      row = $urandom_range(0, 31);
      col = $urandom_range(0, 127);
    end else if (pick < 6 && cursor_gap < TEXT_ROWS * columns) begin
      row = cursor_gap / columns;
      col = cursor_gap % columns;
    end else begin
      row = $urandom_range(0, TEXT_ROWS - 1);
      col = $urandom_range(0, columns - 1);
    end
    // With video on only fully loaded glyphs may be read.
    code = cfg_video_on ? ready_codes[$urandom_range(0, ready_codes.size() - 1)]
                        : $urandom_range(0, 255);
    push_cell(code, $urandom_range(0, 255), row, col);
  endtask

  // Waits until every item is taken and every scan line has come, then lets the block settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_lines.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned draw;
    logic        video;
    logic        wide;
    logic [13:0] start;
    logic [13:0] cursor;
    logic [4:0]  first;
    logic [4:0]  stop;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: video off, narrow mode; edge cells and off-screen cells.
    push_cell(8'hFF, 8'hFF, 0, 0);
    push_cell(8'h00, 8'h00, 24, 39);
    push_cell(8'hAA, 8'h5A, 24, 40);
    push_cell(8'h55, 8'hA5, 25, 0);
    push_cell(8'hFF, 8'hFF, 31, 127);
    push_glyph(8'h00, 64'h00FF_8001_AA55_F00F);
    push_glyph(8'hFF, 64'h0FF0_55AA_0180_FF00);
    wait_drained();

    // Wide mode with the cursor wrapped onto the top left cell, clipped to the whole cell.
    apply_settings(1'b1, 1'b1, 14'h3FFF, 14'h3FFF, 5'd0, 5'd31);
    @(negedge clk);
    push_cell(8'h00, 8'h0F, 0, 0);
    push_cell(8'hFF, 8'hF0, 24, 79);
    push_cell(8'hFF, 8'h3C, 24, 80);
    push_cell(8'h00, 8'hC3, 12, 40);
    wait_drained();

    // Random settings, each with a burst of loads and renders.
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      video  = $urandom_range(0, 9) != 0;
      wide   = 1'($urandom_range(0, 1));
      draw   = $urandom_range(0, 5);
      start  = (draw == 0) ? 14'd0 : (draw == 1) ? 14'h3FFF : 14'($urandom);
      cursor = ($urandom_range(0, 3) != 0)
               ? start + 14'($urandom_range(0, TEXT_ROWS * (wide ? 80 : 40) - 1))
               : 14'($urandom);
      first  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(8, 31))
                                           : 5'($urandom_range(0, 7));
      stop   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(9, 31))
                                           : 5'($urandom_range(0, 8));
      apply_settings(video, wide, start, cursor, first, stop);
      @(negedge clk);
      sender_max_gap     = $urandom_range(0, 1) ? MAX_GAP : 0;
      receiver_max_stall = $urandom_range(0, 1) ? MAX_GAP : 0;
      if (phase == 0) begin
        // Receiver holds off while the sender keeps offering, so the input backs up.
        sender_max_gap = 0;
        hold_cycles <= 300;
      end
      push_glyph($urandom_range(0, 255), {$urandom, $urandom});
      for (int n = 0; n < 30; n++) begin
        if (n == 15 && phase % 2 == 1) begin
          wait_drained();
          @(negedge clk);
        end
        draw = $urandom_range(0, 19);
        if (draw < 2) begin
          push_load($urandom_range(0, GLYPH_STORE_DEPTH - 1), $urandom_range(0, 255));
        end else if (draw == 2) begin
          push_glyph($urandom_range(0, 255), {$urandom, $urandom});
        end else begin
          push_random_cell();
        end
      end
      wait_drained();
      phase++;
    end

    // Everything low, cursor window empty because its end lies before its start.
    apply_settings(1'b0, 1'b0, 14'd0, 14'd0, 5'd31, 5'd0);
    @(negedge clk);
    push_cell(8'hFF, 8'hFF, 0, 0);
    for (int n = 0; n < 6; n++) begin
      push_random_cell();
    end
    wait_drained();

    $display("Covered %0d font loads and %0d rendered cells (%0d dropped, %0d on the cursor)",
             loads_done, cells_rendered, cells_dropped, cursor_cells);
    $display("over %0d register settings; %0d scan lines compared, %0d faults.",
             settings_written, lines_checked, fault_count);
    if (fault_count == 0 && expected_lines.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing scan lines.
  initial begin : watchdog
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
